### src/csma_pkg.sv
package csma_pkg;

	localparam int WINDOW_DEF = 10;

	localparam int CODE_W  = 16;
	localparam int GAIN_W  = 32;
	localparam int CAL_W   = 24;
	localparam int FS_W    = 15;
	localparam int LIGHT_W = 14;
	localparam int PROD_W  = CODE_W + GAIN_W;
	localparam int DEN_W   = FS_W;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_PH_GAIN    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PH_OFFSET  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EC_GAIN    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EC_OFFSET  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_FULL_SCALE = 3'd4;

	localparam int PH_WIN_RST_VAL = 7000;
	localparam int EC_WIN_RST_VAL = 1000;

	localparam logic signed [GAIN_W-1:0] GAIN_RST      = '0;
	localparam logic signed [CAL_W-1:0]  PH_OFFSET_RST = 24'sd7000;
	localparam logic signed [CAL_W-1:0]  EC_OFFSET_RST = 24'sd1000;
	localparam logic [FS_W-1:0]          FS_RST        = 15'd26400;

	localparam logic signed [CAL_W-1:0] CAL_MAX = 24'sh7FFFFF;
	localparam logic signed [CAL_W-1:0] CAL_MIN = 24'sh800000;

	localparam logic [LIGHT_W-1:0]      LIGHT_MAX   = 14'd10000;
	localparam logic signed [GAIN_W-1:0] LIGHT_SCALE = 32'sd10000;

	typedef struct packed {
		logic signed [CODE_W-1:0] ph_code;
		logic signed [CODE_W-1:0] ec_code;
		logic signed [CODE_W-1:0] light_code;
	} in_t;

	typedef struct packed {
		logic signed [CAL_W-1:0] ph_average;
		logic signed [CAL_W-1:0] ec_average;
		logic [LIGHT_W-1:0]      light_percent;
	} out_t;

endpackage

### src/csma_div.sv
module csma_div #(
	parameter int NUM_W = 30
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NUM_W-1:0]            num,
	input  logic [csma_pkg::DEN_W-1:0]  den,
	output logic                        done,
	output logic [NUM_W-1:0]            quo
);
	import csma_pkg::*;

	// radix-4 restoring divider, two quotient bits per cycle
	localparam int STEPS = NUM_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic             running_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W:0]   rem_nx;
	logic [NUM_W-1:0] quo_q;
	logic [NUM_W-1:0] quo_nx;
	logic [DEN_W-1:0] den_q;

	always_comb begin
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int k = 0; k < 2; k++) begin
			rem_nx = {rem_nx[DEN_W-1:0], quo_nx[NUM_W-1]};
			quo_nx = {quo_nx[NUM_W-2:0], 1'b0};
			if (rem_nx >= {1'b0, den_q}) begin
				rem_nx    = rem_nx - {1'b0, den_q};
				quo_nx[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
				cnt_q     <= CNT_W'(STEPS);
			end else if (running_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (running_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### src/calibrated_sensor_moving_average.sv
// Calibrated sensor moving average. Each input transaction carries one pH, conductivity and
// light converter code set. pH and conductivity are calibrated as (code * gain) >>> 16 + offset,
// saturated to 24-bit signed, pushed into a WINDOW-deep ring window each, and the window means
// (truncated toward zero) are returned together with light in hundredths of a percent of
// light_full_scale, clamped to 0..10000. One result transaction follows each input transaction.
// Window sums are kept as running sums; the three divisions share one radix-4 divider that
// resolves two quotient bits per cycle over a 30-bit numerator. After an acceptance in_ready
// returns once the last division is done (the light division is skipped when the light code
// is not positive), and later while the previous result still waits for out_ready. in_ready
// is high only while the block is idle; a
// finished result waits in the output register and the next transaction can be accepted
// meanwhile. Configuration is a plain write port: cfg_we, cfg_index (0 ph_gain, 1 ph_offset,
// 2 ec_gain, 3 ec_offset, 4 light_full_scale), cfg_data; other indexes are ignored.
module calibrated_sensor_moving_average #(
	parameter int WINDOW = csma_pkg::WINDOW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [csma_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [csma_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  csma_pkg::in_t                    in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output csma_pkg::out_t                   out_data
);
	import csma_pkg::*;

	localparam int PW      = $clog2(WINDOW);
	localparam int SUM_W   = CAL_W + PW;
	localparam int NUM_RAW = (SUM_W > 29) ? SUM_W : 29;
	localparam int NUM_W   = NUM_RAW + (NUM_RAW % 2);

	localparam logic signed [SUM_W-1:0] PH_SUM_RST = SUM_W'(PH_WIN_RST_VAL * WINDOW);
	localparam logic signed [SUM_W-1:0] EC_SUM_RST = SUM_W'(EC_WIN_RST_VAL * WINDOW);
	localparam logic signed [CAL_W-1:0] PH_WIN_RST = CAL_W'(PH_WIN_RST_VAL);
	localparam logic signed [CAL_W-1:0] EC_WIN_RST = CAL_W'(EC_WIN_RST_VAL);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_PH_MUL = 9'b000000010,
		S_PH_CAL = 9'b000000100,
		S_EC_CAL = 9'b000001000,
		S_WRITE  = 9'b000010000,
		S_DIV_PH = 9'b000100000,
		S_DIV_EC = 9'b001000000,
		S_DIV_LT = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t state_q;

	logic signed [GAIN_W-1:0] ph_gain_q;
	logic signed [CAL_W-1:0]  ph_offset_q;
	logic signed [GAIN_W-1:0] ec_gain_q;
	logic signed [CAL_W-1:0]  ec_offset_q;
	logic [FS_W-1:0]          fs_q;

	in_t                      in_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [CAL_W-1:0]  cal_ph_q;
	logic signed [CAL_W-1:0]  cal_ec_q;
	logic signed [SUM_W-1:0]  ph_sum_q;
	logic signed [SUM_W-1:0]  ec_sum_q;
	logic [2*CAL_W-1:0]       mem_q [WINDOW];
	logic [2*CAL_W-1:0]       rd_q;
	logic [WINDOW-1:0]        valid_q;
	logic [PW-1:0]            pos_q;
	logic signed [CAL_W-1:0]  ph_avg_q;
	logic signed [CAL_W-1:0]  ec_avg_q;
	logic [LIGHT_W-1:0]       light_q;
	out_t                     out_q;
	logic                     out_valid_q;

	logic signed [CODE_W-1:0] mul_a;
	logic signed [GAIN_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [CAL_W-1:0]  cal_off;
	logic signed [32:0]       cal_sum;
	logic signed [CAL_W-1:0]  cal_sat;
	logic signed [CAL_W-1:0]  old_ph;
	logic signed [CAL_W-1:0]  old_ec;
	logic [SUM_W-1:0]         ph_mag;
	logic [SUM_W-1:0]         ec_mag;
	logic                     light_pos;
	logic                     div_start;
	logic                     div_done;
	logic [NUM_W-1:0]         div_num;
	logic [DEN_W-1:0]         div_den;
	logic [NUM_W-1:0]         div_quo;
	logic signed [CAL_W-1:0]  quo_s;
	logic                     out_load;

	// shared multiplier
	always_comb begin
		unique case (state_q)
			S_PH_MUL: begin
				mul_a = in_q.ph_code;
				mul_b = ph_gain_q;
			end
			S_PH_CAL: begin
				mul_a = in_q.ec_code;
				mul_b = ec_gain_q;
			end
			default: begin
				mul_a = in_q.light_code;
				mul_b = LIGHT_SCALE;
			end
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// floor shift, offset, saturate
	assign cal_off = (state_q == S_PH_CAL) ? ph_offset_q : ec_offset_q;
	assign cal_sum = 33'(prod_q >>> 16) + 33'(cal_off);

	always_comb begin
		priority if (cal_sum > 33'(CAL_MAX))
			cal_sat = CAL_MAX;
		else if (cal_sum < 33'(CAL_MIN))
			cal_sat = CAL_MIN;
		else
			cal_sat = cal_sum[CAL_W-1:0];
	end

	assign old_ph = valid_q[pos_q] ? rd_q[2*CAL_W-1:CAL_W] : PH_WIN_RST;
	assign old_ec = valid_q[pos_q] ? rd_q[CAL_W-1:0] : EC_WIN_RST;

	assign ph_mag    = ph_sum_q[SUM_W-1] ? SUM_W'(-ph_sum_q) : ph_sum_q;
	assign ec_mag    = ec_sum_q[SUM_W-1] ? SUM_W'(-ec_sum_q) : ec_sum_q;
	assign light_pos = in_q.light_code > $signed(CODE_W'(0));

	always_comb begin
		unique case (state_q)
			S_WRITE:  div_num = NUM_W'(ph_mag);
			S_DIV_PH: div_num = NUM_W'(ec_mag);
			default:  div_num = prod_q[NUM_W-1:0];
		endcase
	end

	assign div_den   = (state_q == S_DIV_EC) ? ((fs_q == '0) ? DEN_W'(1) : fs_q)
		: DEN_W'(WINDOW);
	assign div_start = (state_q == S_WRITE)
		|| (div_done && (state_q == S_DIV_PH))
		|| (div_done && (state_q == S_DIV_EC) && light_pos);
	assign quo_s     = div_quo[CAL_W-1:0];

	csma_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo)
	);

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_gain_q   <= GAIN_RST;
			ph_offset_q <= PH_OFFSET_RST;
			ec_gain_q   <= GAIN_RST;
			ec_offset_q <= EC_OFFSET_RST;
			fs_q        <= FS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PH_GAIN:    ph_gain_q   <= cfg_data;
				REG_PH_OFFSET:  ph_offset_q <= cfg_data[CAL_W-1:0];
				REG_EC_GAIN:    ec_gain_q   <= cfg_data;
				REG_EC_OFFSET:  ec_offset_q <= cfg_data[CAL_W-1:0];
				REG_FULL_SCALE: fs_q        <= cfg_data[FS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_sum_q    <= PH_SUM_RST;
			ec_sum_q    <= EC_SUM_RST;
			valid_q     <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_PH_MUL;
				end
				S_PH_MUL: state_q <= S_PH_CAL;
				S_PH_CAL: state_q <= S_EC_CAL;
				S_EC_CAL: begin
					ph_sum_q <= ph_sum_q - SUM_W'(old_ph) + SUM_W'(cal_ph_q);
					state_q  <= S_WRITE;
				end
				S_WRITE: begin
					ec_sum_q       <= ec_sum_q - SUM_W'(old_ec) + SUM_W'(cal_ec_q);
					valid_q[pos_q] <= 1'b1;
					pos_q          <= (pos_q == PW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
					state_q        <= S_DIV_PH;
				end
				S_DIV_PH: begin
					if (div_done)
						state_q <= S_DIV_EC;
				end
				S_DIV_EC: begin
					if (div_done)
						state_q <= light_pos ? S_DIV_LT : S_OUT;
				end
				S_DIV_LT: begin
					if (div_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem_q[pos_q];
		if (state_q == S_WRITE)
			mem_q[pos_q] <= {cal_ph_q, cal_ec_q};
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_q <= in_data;
		if (state_q == S_PH_MUL || state_q == S_PH_CAL || state_q == S_EC_CAL)
			prod_q <= mul_p;
		if (state_q == S_PH_CAL)
			cal_ph_q <= cal_sat;
		if (state_q == S_EC_CAL)
			cal_ec_q <= cal_sat;
		if (div_done && state_q == S_DIV_PH)
			ph_avg_q <= ph_sum_q[SUM_W-1] ? -quo_s : quo_s;
		if (div_done && state_q == S_DIV_EC) begin
			ec_avg_q <= ec_sum_q[SUM_W-1] ? -quo_s : quo_s;
			light_q  <= '0;
		end
		if (div_done && state_q == S_DIV_LT)
			light_q <= (div_quo > NUM_W'(LIGHT_MAX)) ? LIGHT_MAX : div_quo[LIGHT_W-1:0];
		if (out_load) begin
			out_q.ph_average    <= ph_avg_q;
			out_q.ec_average    <= ec_avg_q;
			out_q.light_percent <= light_q;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_pos_advance: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WRITE |=> pos_q == (($past(pos_q) == PW'(WINDOW - 1)) ? '0
			: PW'($past(pos_q) + 1'b1)))
		else $error("ring position did not advance after window write");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_PH || state_q == S_DIV_EC || state_q == S_DIV_LT))
		else $error("divider finished outside a divide step");

	a_light_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.light_percent <= LIGHT_MAX)
		else $error("light percent above full scale");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !in_ready)
		else $error("divider started while idle");

endmodule

### bench/csma_checker.sv
module csma_checker #(
	parameter int WIN = csma_pkg::WINDOW_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [csma_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [csma_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	input  logic                             in_ready,
	input  csma_pkg::in_t                    in_data,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  csma_pkg::out_t                   out_data,
	output int                               pending,
	output int                               errors
);
	timeunit 1ns;
	timeprecision 1ps;
	import csma_pkg::*;

	logic signed [GAIN_W-1:0] ph_gain, ec_gain;
	logic signed [CAL_W-1:0]  ph_ofs, ec_ofs;
	logic [FS_W-1:0]          full_scale;
	logic signed [CAL_W-1:0]  ph_ring [WIN];
	logic signed [CAL_W-1:0]  ec_ring [WIN];
	int                       slot;
	out_t                     mean_q [$];

	function automatic logic signed [CAL_W-1:0] calibrated_value(
		input logic signed [CODE_W-1:0] code,
		input logic signed [GAIN_W-1:0] gain,
		input logic signed [CAL_W-1:0]  ofs
	);
		longint v;
		v = ((longint'(code) * longint'(gain)) >>> 16) + longint'(ofs);
		if (v > longint'(CAL_MAX))
			v = longint'(CAL_MAX);
		if (v < longint'(CAL_MIN))
			v = longint'(CAL_MIN);
		return CAL_W'(v);
	endfunction

	function automatic logic [LIGHT_W-1:0] light_hundredths(input logic signed [CODE_W-1:0] code);
		longint den, q;
		den = (full_scale == '0) ? 1 : longint'(full_scale);
		if (code <= 0)
			return '0;
		q = longint'(code) * longint'(LIGHT_SCALE) / den;
		if (q > longint'(LIGHT_MAX))
			q = longint'(LIGHT_MAX);
		return LIGHT_W'(q);
	endfunction

	// store first, then advance, then average the whole ring
	function automatic out_t advance_windows(input in_t s);
		out_t   r;
		longint ph_sum, ec_sum;
		ph_ring[slot] = calibrated_value(s.ph_code, ph_gain, ph_ofs);
		ec_ring[slot] = calibrated_value(s.ec_code, ec_gain, ec_ofs);
		slot = (slot + 1 >= WIN) ? 0 : slot + 1;
		ph_sum = 0;
		ec_sum = 0;
		for (int i = 0; i < WIN; i++) begin
			ph_sum += ph_ring[i];
			ec_sum += ec_ring[i];
		end
		r.ph_average = CAL_W'(ph_sum / WIN);
		r.ec_average = CAL_W'(ec_sum / WIN);
		r.light_percent = light_hundredths(s.light_code);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		out_t want;
		if (!arst_n) begin
			ph_gain = GAIN_RST;
			ec_gain = GAIN_RST;
			ph_ofs = PH_OFFSET_RST;
			ec_ofs = EC_OFFSET_RST;
			full_scale = FS_RST;
			for (int i = 0; i < WIN; i++) begin
				ph_ring[i] = CAL_W'(PH_WIN_RST_VAL);
				ec_ring[i] = CAL_W'(EC_WIN_RST_VAL);
			end
			slot = 0;
			mean_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PH_GAIN:    ph_gain = cfg_data;
					REG_PH_OFFSET:  ph_ofs = cfg_data[CAL_W-1:0];
					REG_EC_GAIN:    ec_gain = cfg_data;
					REG_EC_OFFSET:  ec_ofs = cfg_data[CAL_W-1:0];
					REG_FULL_SCALE: full_scale = cfg_data[FS_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (mean_q.size() == 0) begin
					report_mismatch("unexpected result transaction", out_data.ph_average, 0);
				end else begin
					want = mean_q.pop_front();
					if (out_data.ph_average !== want.ph_average)
						report_mismatch("ph_average", out_data.ph_average, want.ph_average);
					if (out_data.ec_average !== want.ec_average)
						report_mismatch("ec_average", out_data.ec_average, want.ec_average);
					if (out_data.light_percent !== want.light_percent)
						report_mismatch("light_percent", out_data.light_percent,
							want.light_percent);
				end
			end
			if (in_valid && in_ready)
				mean_q.push_back(advance_windows(in_data));
			pending = mean_q.size();
		end
	end

endmodule

### bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import csma_pkg::*;

	localparam int HOLD  = 80;
	localparam int LIMIT = 3000;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	in_t                    in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_t                   out_data;
	int                     pending;
	int                     errors;

	logic                   calm;
	logic [FS_W-1:0]        fs_now;
	int                     sets_sent;
	int                     settings_used;
	int                     quiet;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	calibrated_sensor_moving_average dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	csma_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.pending  (pending),
		.errors   (errors)
	);

	function automatic int draw_wait();
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic logic [CODE_W-1:0] draw_code();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 300));
			3: return -16'($urandom_range(1, 300));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] draw_light();
		if ($urandom_range(0, 1))
			return 16'($urandom_range(0, fs_now + 16'd50));
		return draw_code();
	endfunction

	function automatic logic [GAIN_W-1:0] draw_gain();
		logic [GAIN_W-1:0] g;
		g = $urandom_range(0, 32'h0040_0000);
		if ($urandom_range(0, 1))
			g = -g;
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return g;
		endcase
	endfunction

	function automatic logic [CAL_W-1:0] draw_offset();
		case ($urandom_range(0, 5))
			0: return 24'h7F_FFFF;
			1: return 24'h80_0000;
			2: return 24'($urandom);
			default: return 24'($urandom_range(0, 14000)) - 24'd2000;
		endcase
	endfunction

	function automatic logic [FS_W-1:0] draw_full_scale();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 15'h7FFF;
			2: return 15'($urandom_range(1, 64));
			default: return 15'($urandom_range(1, 32767));
		endcase
	endfunction

	task automatic push_sample(input logic [CODE_W-1:0] ph, input logic [CODE_W-1:0] ec,
		input logic [CODE_W-1:0] lt);
		int w;
		w = draw_wait();
		repeat (w) @(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{ph_code: ph, ec_code: ec, light_code: lt};
		do @(posedge clk); while (!in_ready);
		sets_sent++;
	endtask

	// sender holds off until every outstanding result has drained
	task automatic drain();
		@(negedge clk) in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (HOLD) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
	endtask

	task automatic program_regs(input logic [GAIN_W-1:0] pg, input logic [CAL_W-1:0] po,
		input logic [GAIN_W-1:0] eg, input logic [CAL_W-1:0] eo, input logic [FS_W-1:0] fs);
		write_reg(REG_PH_GAIN, pg);
		write_reg(REG_PH_OFFSET, {{8{po[CAL_W-1]}}, po});
		write_reg(REG_EC_GAIN, eg);
		write_reg(REG_EC_OFFSET, {{8{eo[CAL_W-1]}}, eo});
		write_reg(REG_FULL_SCALE, CFG_DATA_W'(fs));
		// index past the register list must be dropped
		write_reg(CFG_INDEX_W'(REG_FULL_SCALE + 3'd1 + 3'($urandom_range(0, 2))), $urandom);
		@(negedge clk) cfg_we <= 1'b0;
		fs_now = fs;
		settings_used++;
	endtask

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet <= 0;
		end else if (quiet >= LIMIT) begin
			$display("calibrated_sensor_moving_average verification failed");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : sink
		int w;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			w = draw_wait();
			repeat (w) @(negedge clk) out_ready <= 1'b0;
			@(negedge clk) out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 1'b0;
		fs_now = FS_RST;
		sets_sent = 0;
		settings_used = 1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// power-on calibration
		push_sample(16'sd1000, -16'sd5, 16'sd26400);
		push_sample(16'sd0, 16'sd0, -16'sd1);
		push_sample(16'sd12345, 16'sd32767, 16'sd13200);
		push_sample(-16'sd32768, 16'sd1, 16'sd26401);

		// saturating gains, full scale of one
		drain();
		program_regs(32'h7FFF_FFFF, 24'h7F_FFFF, 32'h8000_0000, 24'h80_0000, 15'd1);
		push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
		push_sample(16'h8000, 16'h8000, 16'h8000);
		push_sample(16'sd0, 16'sd0, 16'sd0);
		push_sample(16'sd1, 16'sd1, 16'sd1);
		push_sample(-16'sd1, -16'sd1, 16'sd1);

		// zero full scale behaves as one
		drain();
		program_regs(32'h0001_0000, 24'h0, 32'hFFFF_0000, 24'h0, 15'd0);
		push_sample(16'sd5, 16'sd5, 16'sd1);
		push_sample(16'sd100, -16'sd100, 16'sd0);
		push_sample(-16'sd32768, 16'sd32767, 16'sd2);

		drain();
		program_regs(32'h0000_8000, -24'sd5000, 32'h0004_0000, 24'sd300, 15'h7FFF);
		push_sample(16'sd32767, 16'sd32767, 16'sd32767);
		push_sample(16'sd16384, -16'sd16384, 16'sd16384);
		push_sample(-16'sd3, 16'sd3, 16'sd3);
		push_sample(16'sd1, 16'sd1, 16'sd32766);

		for (int p = 0; p < 12; p++) begin
			drain();
			program_regs(draw_gain(), draw_offset(), draw_gain(), draw_offset(),
				draw_full_scale());
			calm = ($urandom_range(0, 3) == 0);
			repeat (86) push_sample(draw_code(), draw_code(), draw_light());
		end

		drain();
		$display("Covered %0d sample sets over %0d calibration settings, incl. saturation,",
			sets_sent, settings_used);
		$display("zero and out-of-range full scale, negative light and ignored register writes.");
		if (errors == 0 && pending == 0) begin
			$display("calibrated_sensor_moving_average verification clean");
		end else begin
			$display("calibrated_sensor_moving_average verification failed");
		end
		$finish;
	end

endmodule
